// ===== rtl/core/lmf_pkg.sv =====
// Shared types, sizes and a helper function of the learning bridge MAC table.
// Used by every module in rtl/core; depends on nothing.
package lmf_pkg;

    localparam int TABLE_ENTRIES = 1024;
    localparam int PORT_COUNT    = 4;

    localparam int MAC_W  = 48;
    localparam int PORT_W = 2;
    localparam int MASK_W = 4;
    localparam int IDX_W  = $clog2(TABLE_ENTRIES);
    localparam int CNT_W  = $clog2(TABLE_ENTRIES + 1);

    localparam int S_TDATA_W = 104;
    localparam int M_TDATA_W = 8;

    localparam logic [CNT_W-1:0] TABLE_FULL = CNT_W'(TABLE_ENTRIES);

    typedef logic [MAC_W-1:0]  mac_t;
    typedef logic [PORT_W-1:0] port_t;
    typedef logic [MASK_W-1:0] mask_t;
    typedef logic [IDX_W-1:0]  idx_t;
    typedef logic [CNT_W-1:0]  cnt_t;

    typedef struct packed {
        mac_t  mac;
        port_t port;
    } entry_t;

    typedef struct packed {
        logic  known;
        port_t fwd_port;
        mask_t flood_mask;
        logic  learn_dropped;
    } result_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

    // Every existing port except the ingress port.
    function automatic mask_t flood_mask(input port_t in_port);
        mask_t m;
        for (int b = 0; b < MASK_W; b++) begin
            m[b] = (b < PORT_COUNT) && (PORT_W'(b) != in_port);
        end
        return m;
    endfunction

endpackage

// ===== rtl/core/lmf_table_ram.sv =====
// Single-port-write, single-port-read table memory holding MAC and port per entry.
// Read data is registered. Depends on lmf_pkg.
module lmf_table_ram (
    input  logic            aclk,
    input  logic            we,
    input  lmf_pkg::idx_t   waddr,
    input  lmf_pkg::entry_t wdata,
    input  logic            re,
    input  lmf_pkg::idx_t   raddr,
    output lmf_pkg::entry_t rdata
);

    lmf_pkg::entry_t mem [lmf_pkg::TABLE_ENTRIES];
    lmf_pkg::entry_t rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/lmf_ctrl.sv =====
// Sequencer of the MAC table: scans the filled entries for source and destination,
// then writes back the learned source and hands one result on. Depends on lmf_pkg.
module lmf_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              req_valid,
    output logic              req_ready,
    input  lmf_pkg::mac_t     req_src,
    input  lmf_pkg::mac_t     req_dst,
    input  lmf_pkg::port_t    req_port,
    output logic              res_valid,
    input  logic              res_ready,
    output lmf_pkg::result_t  res,
    output logic              ram_we,
    output lmf_pkg::idx_t     ram_waddr,
    output lmf_pkg::entry_t   ram_wdata,
    output logic              ram_re,
    output lmf_pkg::idx_t     ram_raddr,
    input  lmf_pkg::entry_t   ram_rdata
);

    lmf_pkg::state_t state_reg, state_next;
    lmf_pkg::cnt_t   cnt_reg, cnt_next;
    lmf_pkg::cnt_t   issue_reg, issue_next;
    logic            pend_reg, pend_next;
    lmf_pkg::idx_t   cmp_idx_reg, cmp_idx_next;
    lmf_pkg::mac_t   src_reg, src_next;
    lmf_pkg::mac_t   dst_reg, dst_next;
    lmf_pkg::port_t  port_reg, port_next;
    logic            src_hit_reg, src_hit_next;
    lmf_pkg::idx_t   src_idx_reg, src_idx_next;
    logic            dst_hit_reg, dst_hit_next;
    lmf_pkg::port_t  dst_port_reg, dst_port_next;

    logic more;
    logic full;
    logic dropped;
    logic finish;

    assign more    = issue_reg < cnt_reg;
    assign full    = cnt_reg == lmf_pkg::TABLE_FULL;
    assign dropped = !src_hit_reg && full;
    assign finish  = (state_reg == lmf_pkg::ST_FINISH) && res_ready;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            lmf_pkg::ST_IDLE: begin
                if (req_valid) state_next = lmf_pkg::ST_SCAN;
            end
            lmf_pkg::ST_SCAN: begin
                if (!more && !pend_reg) state_next = lmf_pkg::ST_FINISH;
            end
            lmf_pkg::ST_FINISH: begin
                if (res_ready) state_next = lmf_pkg::ST_IDLE;
            end
            default: state_next = lmf_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        req_ready = 1'b0;
        res_valid = 1'b0;
        ram_re    = 1'b0;
        case (state_reg)
            lmf_pkg::ST_IDLE:   req_ready = 1'b1;
            lmf_pkg::ST_SCAN:   ram_re    = more;
            lmf_pkg::ST_FINISH: res_valid = 1'b1;
            default:            req_ready = 1'b0;
        endcase
    end

    assign ram_raddr       = issue_reg[lmf_pkg::IDX_W-1:0];
    assign ram_we          = finish && !dropped;
    assign ram_waddr       = src_hit_reg ? src_idx_reg : cnt_reg[lmf_pkg::IDX_W-1:0];
    assign ram_wdata.mac   = src_reg;
    assign ram_wdata.port  = port_reg;

    always_comb begin
        res.learn_dropped = dropped;
        if ((dst_reg == src_reg) && !dropped) begin
            res.known      = 1'b1;
            res.fwd_port   = port_reg;
            res.flood_mask = '0;
        end else if (dst_hit_reg) begin
            res.known      = 1'b1;
            res.fwd_port   = dst_port_reg;
            res.flood_mask = '0;
        end else begin
            res.known      = 1'b0;
            res.fwd_port   = '0;
            res.flood_mask = lmf_pkg::flood_mask(port_reg);
        end
    end

    always_comb begin
        cnt_next      = cnt_reg;
        issue_next    = issue_reg;
        pend_next     = 1'b0;
        cmp_idx_next  = cmp_idx_reg;
        src_next      = src_reg;
        dst_next      = dst_reg;
        port_next     = port_reg;
        src_hit_next  = src_hit_reg;
        src_idx_next  = src_idx_reg;
        dst_hit_next  = dst_hit_reg;
        dst_port_next = dst_port_reg;
        if ((state_reg == lmf_pkg::ST_IDLE) && req_valid) begin
            src_next     = req_src;
            dst_next     = req_dst;
            port_next    = req_port;
            issue_next   = '0;
            src_hit_next = 1'b0;
            dst_hit_next = 1'b0;
        end
        if (state_reg == lmf_pkg::ST_SCAN) begin
            if (more) begin
                issue_next   = issue_reg + 1'b1;
                pend_next    = 1'b1;
                cmp_idx_next = issue_reg[lmf_pkg::IDX_W-1:0];
            end
            if (pend_reg) begin
                if (ram_rdata.mac == src_reg) begin
                    src_hit_next = 1'b1;
                    src_idx_next = cmp_idx_reg;
                end
                if (ram_rdata.mac == dst_reg) begin
                    dst_hit_next  = 1'b1;
                    dst_port_next = ram_rdata.port;
                end
            end
        end
        if (finish && !src_hit_reg && !full) begin
            cnt_next = cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= lmf_pkg::ST_IDLE;
            cnt_reg   <= '0;
            pend_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        issue_reg    <= issue_next;
        cmp_idx_reg  <= cmp_idx_next;
        src_reg      <= src_next;
        dst_reg      <= dst_next;
        port_reg     <= port_next;
        src_hit_reg  <= src_hit_next;
        src_idx_reg  <= src_idx_next;
        dst_hit_reg  <= dst_hit_next;
        dst_port_reg <= dst_port_next;
    end

endmodule

// ===== rtl/core/lmf_out_reg.sv =====
// Output register of the MAC table: holds one result until the master side takes it.
// Depends on lmf_pkg.
module lmf_out_reg (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             res_valid,
    output logic             res_ready,
    input  lmf_pkg::result_t res,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [lmf_pkg::M_TDATA_W-1:0] m_tdata,
    output logic             m_tuser
);

    logic             valid_reg, valid_next;
    lmf_pkg::result_t res_reg;

    assign res_ready = !valid_reg || m_tready;

    always_comb begin
        valid_next = valid_reg;
        if (res_ready) valid_next = res_valid;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_ready && res_valid) begin
            res_reg <= res;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tuser  = res_reg.known;
    assign m_tdata  = {1'b0, res_reg.learn_dropped, res_reg.flood_mask, res_reg.fwd_port};

endmodule

// ===== rtl/core/l2_mac_learning_forwarder_unit.sv =====
// Top level of the learning bridge MAC table: request channel, sequencer,
// table memory and output register. Depends on lmf_pkg and the lmf_* modules.
//
//   channel   direction  fields (lowest bit up)
//   s_axis    in         tdata: src_mac[47:0], dst_mac[95:48], in_port[97:96]
//   m_axis    out        tdata: fwd_port[1:0], flood_mask[5:2], learn_dropped[6]
//                        tuser: known[0]
//
// A request passes through these steps in order: acceptance, one memory read per
// learned entry, the compare of the last read, leaving the scan and handing the
// result on, which waits until the output register can take it.
// Reset empties the table at once through the fill count; no clearing pass runs.
// A new request is taken while a result still waits in the output register; the
// sequencer stalls at its end only when that register is still occupied.
module l2_mac_learning_forwarder_unit (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [lmf_pkg::S_TDATA_W-1:0]  s_tdata,   // src_mac, dst_mac, in_port
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [lmf_pkg::M_TDATA_W-1:0]  m_tdata,   // fwd_port, flood_mask, learn_dropped
    output logic                           m_tuser    // known
);

    logic             res_valid;
    logic             res_ready;
    lmf_pkg::result_t res;
    logic             ram_we;
    lmf_pkg::idx_t    ram_waddr;
    lmf_pkg::entry_t  ram_wdata;
    logic             ram_re;
    lmf_pkg::idx_t    ram_raddr;
    lmf_pkg::entry_t  ram_rdata;

    lmf_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req_valid (s_tvalid),
        .req_ready (s_tready),
        .req_src   (s_tdata[47:0]),
        .req_dst   (s_tdata[95:48]),
        .req_port  (s_tdata[97:96]),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    lmf_table_ram u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    lmf_out_reg u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule
